FILE: hw/rtl/fdsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsc_pkg
// Types and constants shared by the firmware download sequencer.
// ----------------------------------------------------------------------------
package fdsc_pkg;

  typedef enum logic [2:0] {
    ST_LOGIN       = 3'd0,
    ST_LOGIN_WAIT  = 3'd1,
    ST_LOGIN_READY = 3'd2,
    ST_DL_DOING    = 3'd3,
    ST_DL_WAIT     = 3'd4,
    ST_DL_DONE     = 3'd5,
    ST_DL_ERROR    = 3'd6,
    ST_WAIT_JUMP   = 3'd7
  } seq_state_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_LOGIN   = 2'd1,
    OP_VERSION = 2'd2,
    OP_CHUNK   = 2'd3
  } opcode_t;

  localparam logic [2:0] SEND_NONE    = 3'd0;
  localparam logic [2:0] SEND_LOGIN   = 3'd1;
  localparam logic [2:0] SEND_VERSION = 3'd2;
  localparam logic [2:0] SEND_CHUNK   = 3'd3;
  localparam logic [2:0] SEND_DONE    = 3'd4;

  localparam logic [1:0] ERASE_NONE   = 2'd0;
  localparam logic [1:0] ERASE_ALL    = 2'd1;
  localparam logic [1:0] ERASE_REGION = 2'd2;

  localparam int          CFG_IDX_W         = 3;
  localparam logic [2:0]  CFG_CHUNK_SIZE    = 3'd0;
  localparam logic [2:0]  CFG_LOGIN_TIMEOUT = 3'd1;
  localparam logic [2:0]  CFG_QUERY_PERIOD  = 3'd2;
  localparam logic [2:0]  CFG_CHUNK_TIMEOUT = 3'd3;
  localparam logic [2:0]  CFG_JUMP_TIMEOUT  = 3'd4;

  localparam logic [15:0] RST_CHUNK_SIZE    = 16'd1024;
  localparam logic [15:0] RST_LOGIN_TIMEOUT = 16'd150;
  localparam logic [15:0] RST_QUERY_PERIOD  = 16'd90;
  localparam logic [15:0] RST_CHUNK_TIMEOUT = 16'd90;
  localparam logic [15:0] RST_JUMP_TIMEOUT  = 16'd90;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        link_ready;
    logic        update_available;
    logic        fields_ok;
    logic [31:0] file_total_size;
    logic        chunk_valid;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_length;
    logic        crc_ok;
    logic        write_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  send_kind;
    logic [15:0] send_serial;
    logic [31:0] req_offset;
    logic [15:0] req_length;
    logic        report_ok;
    logic [1:0]  erase_kind;
    logic [31:0] erase_offset;
    logic [9:0]  erase_pages;
    logic        write_chunk;
    logic        jump_arm;
    logic [2:0]  state_now;
  } out_item_t;

endpackage

FILE: hw/rtl/firmware_download_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_download_sequencer_core
// Login, version query and chunked download sequencer.
//
// Input channel (in_valid/in_ready/in_data) carries ticks and replies; each
// item yields exactly one result on the output channel (out_valid/out_ready/
// out_data). Results appear in the cycle after the item is taken; one item per
// cycle while out_ready holds, set by the single result register behind decode.
// in_ready is high while the result register is empty or being drained, so
// a stalled receiver holds off the input only while a result waits.
// Registers are written through cfg_we/cfg_index/cfg_data, one per cycle;
// indexes past the list are ignored.
// Reset (rst, synchronous) puts the sequencer in LOGIN with counters, offset,
// size, done flag and serial cleared, loads the default register values and
// empties the result register.
// ----------------------------------------------------------------------------
module firmware_download_sequencer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fdsc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fdsc_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [fdsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);
  import fdsc_pkg::*;

  logic [15:0] chunk_size;
  logic [15:0] login_timeout;
  logic [15:0] query_period;
  logic [15:0] chunk_timeout;
  logic [15:0] jump_timeout;

  seq_state_t  seq_state, seq_state_next;
  logic [31:0] tick_count, tick_count_next;
  logic [15:0] query_phase, query_phase_next;
  logic [31:0] recv_offset, recv_offset_next;
  logic [31:0] total_size, total_size_next;
  logic        done_flag, done_flag_next;
  logic [15:0] serial_count, serial_count_next;

  out_item_t   res;
  logic        accept;
  logic        is_tick;
  logic        go;
  logic [15:0] period;
  logic [15:0] phase_base;
  logic [16:0] phase_inc;
  logic [31:0] remain;
  logic [32:0] chunk_end;
  logic        end_beyond;
  opcode_t     op;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = opcode_t'(in_data.opcode);
  assign is_tick  = (op == OP_TICK) && in_data.link_ready;

  assign period     = (query_period == 16'd0) ? 16'd1 : query_period;
  assign remain     = total_size - recv_offset;
  assign chunk_end  = {1'b0, in_data.chunk_offset} + {17'd0, in_data.chunk_length};
  assign end_beyond = chunk_end[32] || (chunk_end[31:0] > total_size);

  // next state and bookkeeping
  always_comb begin
    seq_state_next   = seq_state;
    recv_offset_next = recv_offset;
    total_size_next  = total_size;
    done_flag_next   = done_flag;
    go               = 1'b0;
    unique case (op)
      OP_TICK: begin
        if (in_data.link_ready) begin
          unique case (seq_state)
            ST_LOGIN: begin
              seq_state_next = ST_LOGIN_WAIT; go = 1'b1;
            end
            ST_LOGIN_WAIT: begin
              if (tick_count > {16'd0, login_timeout}) begin
                seq_state_next = ST_LOGIN; go = 1'b1;
              end
            end
            ST_LOGIN_READY: ;
            ST_DL_DOING: begin
              seq_state_next = ST_DL_WAIT; go = 1'b1;
            end
            ST_DL_WAIT: begin
              if (tick_count > {16'd0, chunk_timeout}) begin
                seq_state_next = ST_DL_DOING; go = 1'b1;
              end
            end
            ST_DL_DONE: begin
              seq_state_next = ST_WAIT_JUMP; go = 1'b1;
            end
            ST_DL_ERROR: begin
              seq_state_next = ST_DL_DOING; go = 1'b1;
            end
            ST_WAIT_JUMP: begin
              if (tick_count > {16'd0, jump_timeout}) begin
                seq_state_next = ST_LOGIN; go = 1'b1;
              end
            end
          endcase
        end
      end
      OP_LOGIN: begin
        seq_state_next = ST_LOGIN_READY; go = 1'b1;
      end
      OP_VERSION: begin
        if (in_data.update_available) begin
          total_size_next = in_data.file_total_size;
          if (in_data.fields_ok) begin
            seq_state_next = ST_DL_DOING; go = 1'b1;
          end
        end
      end
      OP_CHUNK: begin
        if (in_data.chunk_valid) begin
          go = 1'b1;
          priority if (in_data.chunk_offset < recv_offset) begin
            seq_state_next = ST_DL_DOING;
          end else if (!in_data.crc_ok) begin
            seq_state_next = ST_DL_DOING;
          end else if (!in_data.write_ok) begin
            seq_state_next = ST_DL_ERROR;
          end else if (end_beyond) begin
            recv_offset_next = 32'd0;
            seq_state_next   = ST_LOGIN;
          end else if (chunk_end[31:0] == total_size) begin
            recv_offset_next = chunk_end[31:0];
            done_flag_next   = 1'b1;
            seq_state_next   = ST_DL_DONE;
          end else begin
            recv_offset_next = chunk_end[31:0];
            seq_state_next   = ST_DL_DOING;
          end
        end
      end
    endcase

    phase_base = go ? 16'd0 : query_phase;
    phase_inc  = {1'b0, phase_base} + 17'd1;
    if (is_tick) begin
      tick_count_next  = (go ? 32'd0 : tick_count) + 32'd1;
      query_phase_next = (phase_inc >= {1'b0, period}) ? 16'd0 : phase_inc[15:0];
    end else begin
      tick_count_next  = go ? 32'd0 : tick_count;
      query_phase_next = phase_base;
    end
  end

  // result fields
  always_comb begin
    res           = '0;
    res.state_now = seq_state_next;
    unique case (op)
      OP_TICK: begin
        if (in_data.link_ready) begin
          unique case (seq_state)
            ST_LOGIN: begin
              res.send_kind   = SEND_LOGIN;
              res.send_serial = serial_count;
            end
            ST_LOGIN_READY: begin
              if (query_phase == 16'd0) begin
                res.send_kind   = SEND_VERSION;
                res.send_serial = serial_count;
              end
            end
            ST_DL_DOING: begin
              res.send_kind   = SEND_CHUNK;
              res.send_serial = serial_count;
              res.req_offset  = recv_offset;
              res.req_length  = (remain > {16'd0, chunk_size}) ? chunk_size : remain[15:0];
            end
            ST_DL_DONE: begin
              res.send_kind   = SEND_DONE;
              res.send_serial = serial_count;
              res.report_ok   = done_flag;
              res.jump_arm    = 1'b1;
            end
            ST_DL_ERROR: begin
              res.erase_kind   = ERASE_REGION;
              res.erase_offset = recv_offset;
              res.erase_pages  = {1'b0, chunk_size[15:7]} + 10'd1;
            end
            default: ;
          endcase
        end
      end
      OP_LOGIN: ;
      OP_VERSION: begin
        if (in_data.update_available) begin
          if (in_data.fields_ok && (recv_offset == 32'd0)) res.erase_kind = ERASE_ALL;
        end else begin
          res.jump_arm = 1'b1;
        end
      end
      OP_CHUNK: begin
        if (in_data.chunk_valid && !(in_data.chunk_offset < recv_offset) && in_data.crc_ok) begin
          res.write_chunk = 1'b1;
        end
      end
    endcase
  end

  assign serial_count_next = (res.send_kind != SEND_NONE) ? serial_count + 16'd1 : serial_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size    <= RST_CHUNK_SIZE;
      login_timeout <= RST_LOGIN_TIMEOUT;
      query_period  <= RST_QUERY_PERIOD;
      chunk_timeout <= RST_CHUNK_TIMEOUT;
      jump_timeout  <= RST_JUMP_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHUNK_SIZE:    chunk_size    <= cfg_data;
        CFG_LOGIN_TIMEOUT: login_timeout <= cfg_data;
        CFG_QUERY_PERIOD:  query_period  <= cfg_data;
        CFG_CHUNK_TIMEOUT: chunk_timeout <= cfg_data;
        CFG_JUMP_TIMEOUT:  jump_timeout  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state    <= ST_LOGIN;
      tick_count   <= '0;
      query_phase  <= '0;
      recv_offset  <= '0;
      total_size   <= '0;
      done_flag    <= 1'b0;
      serial_count <= '0;
    end else if (accept) begin
      seq_state    <= seq_state_next;
      tick_count   <= tick_count_next;
      query_phase  <= query_phase_next;
      recv_offset  <= recv_offset_next;
      total_size   <= total_size_next;
      done_flag    <= done_flag_next;
      serial_count <= serial_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for firmware_download_sequencer_core.
//
// A queue of ticks and replies feeds a bursty valid/ready sender. A
// cycle-level copy of the sequencer (state, tick and query counters, offset,
// size, done flag, serial) runs on every accepted item and queues the result
// it should produce. A monitor behind a stalling receiver checks each result
// field by field against the oldest queued one. The run opens with directed
// items at reset settings, then five register settings (reset, zero timeouts,
// the maxima, small values, random), each driving mostly complete login,
// version and download sessions with faults mixed in, plus random noise.
// ----------------------------------------------------------------------------
module tb;
  import fdsc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  firmware_download_sequencer_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // sequencer copy
  logic [15:0] c_chunk, c_login_to, c_period, c_chunk_to, c_jump_to;
  seq_state_t m_state;
  logic [31:0] m_ticks, m_offset, m_total;
  logic [15:0] m_phase, m_serial;
  logic m_done;

  in_item_t stim_q[$];
  out_item_t expected_results[$];
  int n_items;
  int n_errors = 0;

  function automatic void enter_state(input seq_state_t s);
    m_state = s;
    m_ticks = '0;
    m_phase = '0;
  endfunction

  function automatic out_item_t step_sequencer(input in_item_t it);
    out_item_t r;
    logic [32:0] sum;
    logic [31:0] remain, period;
    r = '0;
    case (opcode_t'(it.opcode))
      OP_TICK: if (it.link_ready) begin
        period = (c_period == 16'd0) ? 32'd1 : {16'd0, c_period};
        case (m_state)
          ST_LOGIN: begin
            r.send_kind = SEND_LOGIN;
            r.send_serial = m_serial;
            m_serial = m_serial + 16'd1;
            enter_state(ST_LOGIN_WAIT);
          end
          ST_LOGIN_WAIT: if (m_ticks > {16'd0, c_login_to}) enter_state(ST_LOGIN);
          ST_LOGIN_READY: if (m_phase == 16'd0) begin
            r.send_kind = SEND_VERSION;
            r.send_serial = m_serial;
            m_serial = m_serial + 16'd1;
          end
          ST_DL_DOING: begin
            remain = m_total - m_offset;
            r.send_kind = SEND_CHUNK;
            r.send_serial = m_serial;
            m_serial = m_serial + 16'd1;
            r.req_offset = m_offset;
            r.req_length = (remain > {16'd0, c_chunk}) ? c_chunk : remain[15:0];
            enter_state(ST_DL_WAIT);
          end
          ST_DL_WAIT: if (m_ticks > {16'd0, c_chunk_to}) enter_state(ST_DL_DOING);
          ST_DL_DONE: begin
            r.send_kind = SEND_DONE;
            r.send_serial = m_serial;
            m_serial = m_serial + 16'd1;
            r.report_ok = m_done;
            r.jump_arm = 1'b1;
            enter_state(ST_WAIT_JUMP);
          end
          ST_DL_ERROR: begin
            r.erase_kind = ERASE_REGION;
            r.erase_offset = m_offset;
            r.erase_pages = c_chunk[15:7] + 10'd1;
            enter_state(ST_DL_DOING);
          end
          ST_WAIT_JUMP: if (m_ticks > {16'd0, c_jump_to}) enter_state(ST_LOGIN);
          default: ;
        endcase
        m_ticks = m_ticks + 32'd1;
        m_phase = ({16'd0, m_phase} + 32'd1 >= period) ? 16'd0 : m_phase + 16'd1;
      end
      OP_LOGIN: enter_state(ST_LOGIN_READY);
      OP_VERSION: begin
        if (it.update_available) begin
          m_total = it.file_total_size;
          if (it.fields_ok) begin
            enter_state(ST_DL_DOING);
            if (m_offset == 32'd0) r.erase_kind = ERASE_ALL;
          end
        end else begin
          r.jump_arm = 1'b1;
        end
      end
      OP_CHUNK: if (it.chunk_valid) begin
        if (it.chunk_offset < m_offset) begin
          enter_state(ST_DL_DOING);
        end else if (it.crc_ok) begin
          r.write_chunk = 1'b1;
          if (it.write_ok) begin
            sum = {1'b0, it.chunk_offset} + {17'd0, it.chunk_length};
            if (sum[32] || sum[31:0] > m_total) begin
              m_offset = '0;
              enter_state(ST_LOGIN);
            end else if (sum[31:0] == m_total) begin
              m_offset = sum[31:0];
              m_done = 1'b1;
              enter_state(ST_DL_DONE);
            end else begin
              m_offset = sum[31:0];
              enter_state(ST_DL_DOING);
            end
          end else begin
            enter_state(ST_DL_ERROR);
          end
        end else begin
          enter_state(ST_DL_DOING);
        end
      end
      default: ;
    endcase
    r.state_now = m_state;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  // stimulus builders
  function automatic in_item_t rand_item();
    in_item_t x;
    x.opcode = 2'($urandom_range(0, 3));
    x.link_ready = 1'($urandom);
    x.update_available = 1'($urandom);
    x.fields_ok = 1'($urandom);
    x.file_total_size = $urandom;
    x.chunk_valid = 1'($urandom);
    x.chunk_offset = $urandom;
    x.chunk_length = 16'($urandom);
    x.crc_ok = 1'($urandom);
    x.write_ok = 1'($urandom);
    return x;
  endfunction

  function automatic void add_raw(input in_item_t x);
    stim_q.push_back(x);
    if (!((x.opcode == OP_TICK && !x.link_ready) || (x.opcode == OP_CHUNK && !x.chunk_valid)))
      n_items++;
  endfunction

  function automatic void add_tick(input bit link);
    in_item_t x;
    x = rand_item();
    x.opcode = OP_TICK;
    x.link_ready = link;
    add_raw(x);
  endfunction

  function automatic void add_login_reply();
    in_item_t x;
    x = rand_item();
    x.opcode = OP_LOGIN;
    add_raw(x);
  endfunction

  function automatic void add_version(input bit upd, input bit fok, input logic [31:0] total);
    in_item_t x;
    x = rand_item();
    x.opcode = OP_VERSION;
    x.update_available = upd;
    x.fields_ok = fok;
    x.file_total_size = total;
    add_raw(x);
  endfunction

  function automatic void add_chunk(input bit cv, input logic [31:0] off,
                                    input logic [15:0] len, input bit crc, input bit wok);
    in_item_t x;
    x = rand_item();
    x.opcode = OP_CHUNK;
    x.chunk_valid = cv;
    x.chunk_offset = off;
    x.chunk_length = len;
    x.crc_ok = crc;
    x.write_ok = wok;
    add_raw(x);
  endfunction

  // one login / version / download / done session with faults mixed in
  task automatic add_session();
    logic [31:0] off, total, remain;
    logic [15:0] len;
    int nchunks;
    off = m_offset;
    if ($urandom_range(0, 3) == 0) add_tick(1'b0);
    add_tick(1'b1);
    if (c_login_to < 16'd6 && $urandom_range(0, 3) == 0)
      repeat (c_login_to + 2) add_tick(1'b1);
    add_login_reply();
    repeat ($urandom_range(0, 3)) add_tick(1'b1);
    if ($urandom_range(0, 9) == 0) add_version(1'b0, 1'($urandom), $urandom);
    if ($urandom_range(0, 9) == 0) add_version(1'b1, 1'b0, $urandom);
    total = off + $urandom_range(1, 3 * c_chunk + 3);
    add_version(1'b1, 1'b1, total);
    nchunks = 0;
    while (off != total && nchunks < 8) begin
      remain = total - off;
      len = (remain > {16'd0, c_chunk}) ? c_chunk : remain[15:0];
      add_tick(1'b1);
      if ($urandom_range(0, 4) == 0) add_tick(1'b0);
      case ($urandom_range(0, 11))
        0: begin
          add_chunk(1'b1, off, len, 1'b0, 1'($urandom));
          add_tick(1'b1);
        end
        1: begin
          add_chunk(1'b1, off, len, 1'b1, 1'b0);
          add_tick(1'b1);
          add_tick(1'b1);
        end
        2: if (off != 32'd0) begin
          add_chunk(1'b1, off - 32'd1, len, 1'b1, 1'b1);
          add_tick(1'b1);
        end
        3: if (c_chunk_to < 16'd6) repeat (c_chunk_to + 3) add_tick(1'b1);
        4: add_chunk(1'b0, off, len, 1'b1, 1'b1);
        default: ;
      endcase
      add_chunk(1'b1, off, len, 1'b1, 1'b1);
      off = off + {16'd0, len};
      nchunks++;
    end
    add_tick(1'b1);
    if (c_jump_to < 16'd8) repeat (c_jump_to + 2) add_tick(1'b1);
    else repeat ($urandom_range(0, 2)) add_tick(1'b1);
    repeat ($urandom_range(0, 2)) add_raw(rand_item());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      CFG_CHUNK_SIZE: c_chunk = v;
      CFG_LOGIN_TIMEOUT: c_login_to = v;
      CFG_QUERY_PERIOD: c_period = v;
      CFG_CHUNK_TIMEOUT: c_chunk_to = v;
      CFG_JUMP_TIMEOUT: c_jump_to = v;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] cs, input logic [15:0] lt,
                            input logic [15:0] qp, input logic [15:0] ct,
                            input logic [15:0] jt);
    write_reg(CFG_CHUNK_SIZE, cs);
    write_reg(CFG_LOGIN_TIMEOUT, lt);
    write_reg(CFG_QUERY_PERIOD, qp);
    write_reg(CFG_CHUNK_TIMEOUT, ct);
    write_reg(CFG_JUMP_TIMEOUT, jt);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (stim_q.size() != 0 || in_valid || expected_results.size() != 0) @(negedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic run_sessions(input int count);
    n_items = 0;
    while (n_items < count) begin
      while (stim_q.size() != 0 || in_valid) @(negedge clk);
      add_session();
    end
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(step_sequencer(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= stim_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall patterns, one long hold
  int rx_count = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) rx_count++;
      rx_cycle++;
      if (!hold_done && rx_count >= 150) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_cycle[6:5])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_ready <= 1'($urandom);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // result check
  int result_idx = 0;

  always @(posedge clk) begin
    out_item_t want;
    string diff;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result %0d with no item pending: %h", result_idx, out_data));
      end else begin
        want = expected_results.pop_front();
        diff = "";
        if (out_data.send_kind !== want.send_kind) diff = {diff, " send_kind"};
        if (out_data.send_serial !== want.send_serial) diff = {diff, " send_serial"};
        if (out_data.req_offset !== want.req_offset) diff = {diff, " req_offset"};
        if (out_data.req_length !== want.req_length) diff = {diff, " req_length"};
        if (out_data.report_ok !== want.report_ok) diff = {diff, " report_ok"};
        if (out_data.erase_kind !== want.erase_kind) diff = {diff, " erase_kind"};
        if (out_data.erase_offset !== want.erase_offset) diff = {diff, " erase_offset"};
        if (out_data.erase_pages !== want.erase_pages) diff = {diff, " erase_pages"};
        if (out_data.write_chunk !== want.write_chunk) diff = {diff, " write_chunk"};
        if (out_data.jump_arm !== want.jump_arm) diff = {diff, " jump_arm"};
        if (out_data.state_now !== want.state_now) diff = {diff, " state_now"};
        if (diff != "")
          flag_error($sformatf("result %0d:%s got %h exp %h", result_idx, diff, out_data, want));
      end
      result_idx++;
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[firmware_download_sequencer_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    c_chunk = RST_CHUNK_SIZE;
    c_login_to = RST_LOGIN_TIMEOUT;
    c_period = RST_QUERY_PERIOD;
    c_chunk_to = RST_CHUNK_TIMEOUT;
    c_jump_to = RST_JUMP_TIMEOUT;
    m_state = ST_LOGIN;
    m_ticks = '0;
    m_phase = '0;
    m_offset = '0;
    m_total = '0;
    m_done = 1'b0;
    m_serial = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings
    add_raw('0);
    add_tick(1'b1);
    add_tick(1'b1);
    add_login_reply();
    add_tick(1'b1);
    add_tick(1'b1);
    add_version(1'b0, 1'b1, 32'hFFFF_FFFF);
    add_version(1'b1, 1'b0, 32'hFFFF_FFFF);
    add_version(1'b1, 1'b1, 32'd3000);
    add_tick(1'b1);
    add_chunk(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
    add_chunk(1'b1, 32'd0, 16'd1024, 1'b0, 1'b1);
    add_tick(1'b1);
    add_chunk(1'b1, 32'd0, 16'd1024, 1'b1, 1'b0);
    add_tick(1'b1);
    add_chunk(1'b1, 32'd0, 16'd1024, 1'b1, 1'b1);
    add_chunk(1'b1, 32'd0, 16'd16, 1'b1, 1'b1);
    add_chunk(1'b1, 32'd1024, 16'd1976, 1'b1, 1'b1);
    add_tick(1'b1);
    add_version(1'b1, 1'b1, 32'd5000);
    add_chunk(1'b1, 32'hFFFF_FFF0, 16'hFFFF, 1'b1, 1'b1);
    add_chunk(1'b1, 32'd200, 16'd5000, 1'b1, 1'b1);
    add_tick(1'b0);
    add_tick(1'b1);
    add_raw('1);
    run_sessions(64);

    wait_idle();
    set_config(16'd4, 16'd0, 16'd0, 16'd0, 16'd0);
    run_sessions(64);

    wait_idle();
    set_config(16'd65532, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_sessions(64);

    wait_idle();
    set_config(16'd128, 16'd3, 16'd1, 16'd2, 16'd4);
    run_sessions(64);

    wait_idle();
    set_config(16'($urandom_range(1, 64) * 4), 16'($urandom_range(0, 5)),
               16'($urandom_range(1, 6)), 16'($urandom_range(0, 5)),
               16'($urandom_range(0, 5)));
    run_sessions(64);

    wait_idle();
    repeat (4) @(posedge clk);
    if (n_errors == 0) begin
      $display("[firmware_download_sequencer_core] OK");
    end else begin
      $display("[firmware_download_sequencer_core] ERROR");
    end
    $finish;
  end

endmodule
